@@ hw/rtl/scfb_pkg.sv @@
// scfb_pkg: types and constants shared by the frame builder modules.
// Holds the queue entry struct, the byte-position constants and the frame marks.
// Depends on nothing.
package scfb_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] HEAD_A = 8'h7D;
   localparam logic [7:0] HEAD_B = 8'h95;
   localparam logic [7:0] TAIL_A = 8'h6A;
   localparam logic [7:0] TAIL_B = 8'hE2;

   localparam int unsigned HDR_BYTES = 12;

   typedef logic [3:0] pos_type;

   localparam pos_type POS_FIRST    = 4'd0;
   localparam pos_type POS_HDR_LAST = 4'd11;
   localparam pos_type POS_CSUM     = 4'd12;
   localparam pos_type POS_TAIL_A   = 4'd13;
   localparam pos_type POS_TAIL_B   = 4'd14;

   typedef enum logic {
      KIND_HEADER  = 1'b0,
      KIND_PAYLOAD = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        close;
      logic [7:0]  cmd;
      logic [7:0]  payload_len;
      logic [31:0] target_addr;
      logic [31:0] sender_addr;
      logic [7:0]  data_byte;
   } entry_type;

endpackage

@@ hw/rtl/scfb_front.sv @@
// scfb_front: accepts input items, tracks the open frame and classifies each item.
// Pushes header and payload entries into the queue; drops payload with no frame open.
// Depends on scfb_pkg.
module scfb_front import scfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_cmd,
   input  logic [7:0]  req_payload_len,
   input  logic [31:0] req_target_addr,
   input  logic [31:0] req_sender_addr,
   input  logic [7:0]  req_data_byte,
   input  logic        q_full,
   output logic        q_push,
   output entry_type   q_entry
);

   logic       open_ff, open_in;
   logic [7:0] left_ff, left_in;
   logic       accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      open_in             = open_ff;
      left_in             = left_ff;
      q_push              = 1'b0;
      q_entry.kind        = (req_mode == 1'b0) ? KIND_HEADER : KIND_PAYLOAD;
      q_entry.close       = 1'b0;
      q_entry.cmd         = req_cmd;
      q_entry.payload_len = req_payload_len;
      q_entry.target_addr = req_target_addr;
      q_entry.sender_addr = req_sender_addr;
      q_entry.data_byte   = req_data_byte;
      if (accept) begin
         if (req_mode == 1'b0) begin
            q_push        = 1'b1;
            q_entry.close = (req_payload_len == 8'd0);
            open_in       = (req_payload_len != 8'd0);
            left_in       = req_payload_len;
         end else if (open_ff) begin
            q_push        = 1'b1;
            q_entry.close = (left_ff == 8'd1);
            open_in       = (left_ff != 8'd1);
            left_in       = left_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= 8'd0;
      end else begin
         open_ff <= open_in;
         left_ff <= left_in;
      end
   end

endmodule

@@ hw/rtl/scfb_queue.sv @@
// scfb_queue: short FIFO of classified entries between front and back.
// Push and pop may happen in the same cycle, also when full.
// Depends on scfb_pkg.
module scfb_queue import scfb_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   entry_type       mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_pop  = pop && !empty;
   assign do_push = push && (!full || do_pop);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/scfb_back.sv @@
// scfb_back: serializes queue entries into frame bytes with the running checksum.
// Drives the registered output channel; pops an entry after its last byte.
// Depends on scfb_pkg.
module scfb_back import scfb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  entry_type  q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end
);

   pos_type     pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;
   logic        advance;
   logic        is_hdr;
   logic [HDR_BYTES*8-1:0] hdr_vec;
   logic [7:0]  cur_byte;
   logic [3:0]  sel;

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = end_ff;

   assign advance = !valid_ff || !rsp_stall;
   assign is_hdr  = (q_head.kind == KIND_HEADER);
   assign hdr_vec = {HEAD_A, HEAD_B, q_head.cmd, q_head.payload_len,
                     q_head.target_addr, q_head.sender_addr};
   assign sel     = POS_HDR_LAST - pos_ff;

   always_comb begin
      priority if (pos_ff == POS_CSUM) begin
         cur_byte = ~sum_ff;
      end else if (pos_ff == POS_TAIL_A) begin
         cur_byte = TAIL_A;
      end else if (pos_ff == POS_TAIL_B) begin
         cur_byte = TAIL_B;
      end else if (is_hdr) begin
         cur_byte = hdr_vec[{sel, 3'b000} +: 8];
      end else begin
         cur_byte = q_head.data_byte;
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      q_pop    = 1'b0;
      if (advance) begin
         valid_in = !q_empty;
         byte_in  = cur_byte;
         end_in   = (pos_ff == POS_TAIL_B);
         if (!q_empty) begin
            if (pos_ff < POS_CSUM) begin
               sum_in = (is_hdr && pos_ff == POS_FIRST) ? cur_byte : sum_ff + cur_byte;
            end
            priority if (pos_ff == POS_TAIL_B) begin
               pos_in = POS_FIRST;
               q_pop  = 1'b1;
            end else if (pos_ff >= POS_CSUM) begin
               pos_in = pos_ff + 4'd1;
            end else if (is_hdr && pos_ff != POS_HDR_LAST) begin
               pos_in = pos_ff + 4'd1;
            end else if (q_head.close) begin
               pos_in = POS_CSUM;
            end else begin
               pos_in = POS_FIRST;
               q_pop  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_FIRST;
         sum_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

endmodule

@@ hw/rtl/sum_checked_frame_builder.sv @@
// sum_checked_frame_builder: top level of the checksummed frame builder.
// Instantiates scfb_front, scfb_queue and scfb_back; depends on scfb_pkg.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   mode, cmd, payload_len, target/sender addr, data
//   rsp_     out        rsp_valid/rsp_stall   out_byte, frame_end
//
// A header item yields 12 output bytes, 15 when its length is zero.
// A payload item yields 1 output byte, 4 for the last one of a frame.
// The back end emits one byte per cycle while rsp_stall is low; the queue lets
// the front run ahead by up to QUEUE_DEPTH items, after which req_stall rises.
// Reset is synchronous and clears the frame state, the queue and rsp_valid.
module sum_checked_frame_builder import scfb_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_cmd,
   input  logic [7:0]  req_payload_len,
   input  logic [31:0] req_target_addr,
   input  logic [31:0] req_sender_addr,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end
);

   logic      q_full, q_push, q_pop, q_empty;
   entry_type q_entry, q_head;

   scfb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_cmd         (req_cmd),
      .req_payload_len (req_payload_len),
      .req_target_addr (req_target_addr),
      .req_sender_addr (req_sender_addr),
      .req_data_byte   (req_data_byte),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   scfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   scfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

@@ hw/rtl/scfb_checker.sv @@
// scfb_checker: port-level assertions for sum_checked_frame_builder, bound to the top.
// Tracks accepted output items to check frame boundaries.
// Depends on scfb_pkg.
module scfb_checker import scfb_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_frame_end
);

   logic       rsp_take;
   logic [7:0] prev_byte_ff;
   logic       at_start_ff;

   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff <= 8'd0;
         at_start_ff  <= 1'b1;
      end else if (rsp_take) begin
         prev_byte_ff <= rsp_out_byte;
         at_start_ff  <= rsp_frame_end;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_frame_end))
      else $error("rsp item changed while stalled");

   a_end_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_frame_end |-> rsp_out_byte == TAIL_B && prev_byte_ff == TAIL_A)
      else $error("frame end without tail bytes");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_take && at_start_ff |-> rsp_out_byte == HEAD_A)
      else $error("frame does not open with head byte");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind sum_checked_frame_builder scfb_checker u_scfb_checker (.*);

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for sum_checked_frame_builder.
// Predicts every wire byte of each frame, compares it with the block's output and paces both
// channels at random in most tests; depends on scfb_pkg and the sum_checked_frame_builder RTL.
`timescale 1ns / 1ps

module tb_top;
   import scfb_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 200000;
   localparam int unsigned SETTLE_CYCLES    = 40;
   localparam int unsigned LONG_HOLD_CYCLES = 250;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } wire_byte_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_mode        = 1'b0;
   logic [7:0]  req_cmd         = '0;
   logic [7:0]  req_payload_len = '0;
   logic [31:0] req_target_addr = '0;
   logic [31:0] req_sender_addr = '0;
   logic [7:0]  req_data_byte   = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;

   // predictor state
   logic [7:0]    frame_sum    = '0;
   logic [7:0]    bytes_due    = '0;
   bit            frame_active = 1'b0;
   wire_byte_type wire_bytes_q[$];

   int unsigned error_count     = 0;
   int unsigned items_accepted  = 0;
   int unsigned bytes_checked   = 0;
   int unsigned frames_closed   = 0;
   int unsigned frames_aborted  = 0;
   int unsigned strays_dropped  = 0;
   int unsigned cycle_count     = 0;

   bit          req_pace_en = 1'b1;
   bit          rsp_pace_en = 1'b1;
   int unsigned hold_reqs   = 0;
   int unsigned hold_done   = 0;
   int unsigned hold_cnt    = 0;

   sum_checked_frame_builder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_cmd         (req_cmd),
      .req_payload_len (req_payload_len),
      .req_target_addr (req_target_addr),
      .req_sender_addr (req_sender_addr),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_end   (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
                  wire_bytes_q.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   function automatic void push_wire_byte(logic [7:0] value, bit summed, bit last);
      wire_byte_type b;
      b.value = value;
      b.last  = last;
      wire_bytes_q.push_back(b);
      if (summed)
         frame_sum = frame_sum + value;
   endfunction

   function automatic void close_frame();
      push_wire_byte(~frame_sum, 1'b0, 1'b0);
      push_wire_byte(TAIL_A, 1'b0, 1'b0);
      push_wire_byte(TAIL_B, 1'b0, 1'b1);
      frame_active = 1'b0;
      bytes_due    = '0;
      frame_sum    = '0;
      frames_closed++;
   endfunction

   // expands one accepted item into the wire bytes it causes
   function automatic void expand_item(kind_type kind, logic [7:0] cmd, logic [7:0] len,
                                       logic [31:0] tgt, logic [31:0] src,
                                       logic [7:0] data);
      if (kind == KIND_HEADER) begin
         if (frame_active)
            frames_aborted++;
         frame_sum = '0;
         push_wire_byte(HEAD_A, 1'b1, 1'b0);
         push_wire_byte(HEAD_B, 1'b1, 1'b0);
         push_wire_byte(cmd, 1'b1, 1'b0);
         push_wire_byte(len, 1'b1, 1'b0);
         for (int i = 3; i >= 0; i--)
            push_wire_byte(tgt[8*i +: 8], 1'b1, 1'b0);
         for (int i = 3; i >= 0; i--)
            push_wire_byte(src[8*i +: 8], 1'b1, 1'b0);
         bytes_due    = len;
         frame_active = 1'b1;
         if (len == 8'd0)
            close_frame();
      end else if (frame_active) begin
         push_wire_byte(data, 1'b1, 1'b0);
         bytes_due = bytes_due - 8'd1;
         if (bytes_due == 8'd0)
            close_frame();
      end else begin
         strays_dropped++;
      end
   endfunction

   // results are checked before the item accepted at the same edge is expanded
   always @(posedge clock) begin : frame_monitor
      wire_byte_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (wire_bytes_q.size() == 0) begin
               $error("unexpected byte %02h, frame_end %0b", rsp_out_byte, rsp_frame_end);
               error_count++;
            end else begin
               want = wire_bytes_q.pop_front();
               bytes_checked++;
               if (rsp_out_byte !== want.value) begin
                  $error("out_byte mismatch: expected %02h, got %02h", want.value,
                         rsp_out_byte);
                  error_count++;
               end
               if (rsp_frame_end !== want.last) begin
                  $error("frame_end mismatch: expected %0b, got %0b", want.last,
                         rsp_frame_end);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            items_accepted++;
            expand_item(kind_type'(req_mode), req_cmd, req_payload_len, req_target_addr,
                        req_sender_addr, req_data_byte);
         end
      end
   end

   // receiver: random wait after each byte, plus long holds on request
   always @(posedge clock) begin : rsp_pacing
      int unsigned wait_n;
      if (hold_done != hold_reqs) begin
         hold_done <= hold_reqs;
         hold_cnt  <= LONG_HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 1) begin
         hold_cnt <= hold_cnt - 1;
      end else if (hold_cnt == 1) begin
         hold_cnt  <= 0;
         rsp_stall <= 1'b0;
      end else if (rsp_valid === 1'b1 && !rsp_stall) begin
         wait_n = rsp_pace_en ? $urandom_range(0, 9) : 0;
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            hold_cnt  <= wait_n;
         end
      end
   end

   task automatic send_item(kind_type kind, logic [7:0] cmd, logic [7:0] len,
                            logic [31:0] tgt, logic [31:0] src, logic [7:0] data);
      int unsigned gap;
      gap = req_pace_en ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= kind;
      req_cmd         <= cmd;
      req_payload_len <= len;
      req_target_addr <= tgt;
      req_sender_addr <= src;
      req_data_byte   <= data;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic send_header(logic [7:0] cmd, logic [7:0] len, logic [31:0] tgt,
                              logic [31:0] src);
      send_item(KIND_HEADER, cmd, len, tgt, src, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_payload(logic [7:0] data);
      send_item(KIND_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                $urandom, $urandom, data);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (wire_bytes_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_stray_payload();
      send_payload(8'h00);
      send_payload(8'hFF);
      wait_drained();
   endtask

   task automatic test_empty_frames();
      send_header(8'h00, 8'd0, 32'h0000_0000, 32'h0000_0000);
      send_header(8'hFF, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_drained();
   endtask

   task automatic test_short_frames();
      send_header(8'($urandom_range(0, 255)), 8'd1, $urandom, $urandom);
      send_payload(8'hFF);
      send_header(8'($urandom_range(0, 255)), 8'd2, $urandom, $urandom);
      send_payload(8'h00);
      send_payload(8'hA5);
      wait_drained();
   endtask

   task automatic test_aborted_frame();
      send_header(8'h5A, 8'd255, $urandom, $urandom);
      repeat (3) send_payload(8'($urandom_range(0, 255)));
      send_header(8'hC3, 8'd1, $urandom, $urandom);
      send_payload(8'($urandom_range(0, 255)));
      send_payload(8'($urandom_range(0, 255)));   // frame already closed: dropped
      wait_drained();
   endtask

   // receiver holds off while the sender keeps going, so the input stalls
   task automatic test_backpressure();
      req_pace_en = 1'b0;
      hold_reqs++;
      repeat (3) send_header(8'($urandom_range(0, 255)), 8'd0, $urandom, $urandom);
      send_header(8'($urandom_range(0, 255)), 8'd4, $urandom, $urandom);
      repeat (4) send_payload(8'($urandom_range(0, 255)));
      wait_drained();
      req_pace_en = 1'b1;
   endtask

   task automatic test_random_frames(int unsigned quota, bit req_paced, bit rsp_paced);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      int unsigned cut;
      bit          left_open;
      sent        = 0;
      left_open   = 1'b0;
      req_pace_en = req_paced;
      rsp_pace_en = rsp_paced;
      while (sent < quota) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 40);
         if (pick < 8 && !left_open) begin
            send_payload(8'($urandom_range(0, 255)));
            sent += 1;
         end else if (pick < 20) begin
            len = $urandom_range(2, 40);
            cut = $urandom_range(0, len - 1);
            send_header(8'($urandom_range(0, 255)), 8'(len), $urandom, $urandom);
            repeat (cut) send_payload(8'($urandom_range(0, 255)));
            left_open = 1'b1;
            sent += 1 + cut;
         end else begin
            send_header(8'($urandom_range(0, 255)), 8'(len), $urandom, $urandom);
            repeat (len) send_payload(8'($urandom_range(0, 255)));
            left_open = 1'b0;
            sent += 1 + len;
         end
      end
      wait_drained();
      req_pace_en = 1'b1;
      rsp_pace_en = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_stray_payload();
      test_empty_frames();
      test_short_frames();
      test_aborted_frame();
      test_backpressure();
      test_random_frames(140, 1'b1, 1'b1);
      test_random_frames(60, 1'b0, 1'b0);
      test_random_frames(60, 1'b0, 1'b1);

      $display("tb_top: %0d items accepted, %0d wire bytes checked, %0d mismatches",
               items_accepted, bytes_checked, error_count);
      $display("tb_top: %0d frames closed, %0d cut short by a new header, %0d stray payloads",
               frames_closed, frames_aborted, strays_dropped);
      if (error_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
